// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hrs_pkg.sv =====
// Types, codes and constants shared by the HTTP request header scanner.
`timescale 1ns / 1ps
`default_nettype none
package hrs_pkg;

  // Default width of the URL byte counter
  localparam int URL_COUNT_BITS_DEF = 12;

  // Register reset values
  localparam logic [5:0]  METHOD_LIMIT_RST  = 6'd32;
  localparam logic [11:0] URL_LIMIT_RST     = 12'd1024;
  localparam logic [5:0]  VERSION_LIMIT_RST = 6'd32;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_METHOD_LIMIT  = 2'd0;
  localparam logic [1:0] REG_URL_LIMIT     = 2'd1;
  localparam logic [1:0] REG_VERSION_LIMIT = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Token classes
  localparam logic [2:0] CLS_DELIM   = 3'd0;
  localparam logic [2:0] CLS_METHOD  = 3'd1;
  localparam logic [2:0] CLS_URL     = 3'd2;
  localparam logic [2:0] CLS_VERSION = 3'd3;
  localparam logic [2:0] CLS_HEADER  = 3'd4;

  // Status codes
  localparam logic [3:0] ST_PENDING      = 4'd0;
  localparam logic [3:0] ST_OK           = 4'd1;
  localparam logic [3:0] ST_METHOD_LONG  = 4'd2;
  localparam logic [3:0] ST_URL_LONG     = 4'd3;
  localparam logic [3:0] ST_VERSION_LONG = 4'd4;
  localparam logic [3:0] ST_BAD_METHOD   = 4'd5;
  localparam logic [3:0] ST_BAD_URL      = 4'd6;
  localparam logic [3:0] ST_FORMAT       = 4'd7;
  localparam logic [3:0] ST_HEADERS      = 4'd8;

  // Scan phase
  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URL,
    PH_VERSION,
    PH_VERSION_CR,
    PH_HDR,
    PH_HDR_CR,
    PH_HDR_BLANK,
    PH_HDR_BLANK_CR
  } phase_t;

  // Input beat: one raw byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Output beat: tagged byte
  typedef struct packed {
    logic [7:0] echo_byte;
    logic [2:0] token_class;
    logic       name_value_split;
    logic [3:0] status;
    logic       crlf_error;
  } out_beat_t;

  // Programmed length limits
  typedef struct packed {
    logic [5:0]  method_limit;
    logic [11:0] url_limit;
    logic [5:0]  version_limit;
  } limits_t;

  // Scanner state apart from the URL counter
  typedef struct packed {
    phase_t     phase;
    logic [5:0] method_count;
    logic [5:0] version_count;
    logic       prev_was_colon;
    logic       line_has_split;
    logic       bad_line_seen;
    logic       finished;
    logic [3:0] held_status;
    logic       held_crlf;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    phase:          PH_METHOD,
    method_count:   6'd0,
    version_count:  6'd0,
    prev_was_colon: 1'b0,
    line_has_split: 1'b0,
    bad_line_seen:  1'b0,
    finished:       1'b0,
    held_status:    ST_PENDING,
    held_crlf:      1'b0
  };

endpackage
`default_nettype wire

// ===== rtl/http_request_header_scanner_core.sv =====
// Top level of the HTTP request header scanner.
// Usage:
//   Raw request bytes enter on the byte channel (byte_valid / byte_stall /
//   byte_beat), one byte per beat; last_byte marks the end of a request
//   buffer. Each byte produces exactly one tagged beat on the tag channel
//   (tag_valid / tag_stall / tag_beat): the byte echoed, its token class,
//   the name/value split mark, the status and the CR/LF error flag.
//   Each tag beat is registered in the result queue. Throughput is one byte
//   per cycle while byte_stall is low; the scan state is updated by a
//   single combinational step between the state registers and a result
//   queue. The two-entry result queue lets the scanner keep accepting while
//   one finished beat waits; byte_stall rises only when both entries are
//   full, and it is driven from a register. Length limits are set over the
//   APB port (method, URL, version at byte addresses 0, 4, 8); the user must
//   write them only while the block is idle; the block does not enforce this.
//   Reset clears the scan state, empties the queue and loads the default
//   limits; the scan state also restarts after every byte with last_byte set.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module http_request_header_scanner_core import hrs_pkg::*; #(
  parameter int URL_COUNT_BITS = URL_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  in_beat_t         byte_beat,
  output logic             tag_valid,
  input  wire logic        tag_stall,
  output out_beat_t        tag_beat,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  limits_t                   limits;
  scan_state_t               st;
  scan_state_t               st_next;
  logic [URL_COUNT_BITS-1:0] url_count;
  logic [URL_COUNT_BITS-1:0] url_count_next;
  out_beat_t                 result;
  logic                      accept;

  assign accept = byte_valid && !byte_stall;

  hrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  hrs_step #(
    .URL_COUNT_BITS (URL_COUNT_BITS)
  ) u_step (
    .st             (st),
    .url_count      (url_count),
    .limits         (limits),
    .beat           (byte_beat),
    .st_next        (st_next),
    .url_count_next (url_count_next),
    .result         (result)
  );

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= SCAN_CLEAR;
      url_count <= '0;
    end else if (accept) begin
      st        <= st_next;
      url_count <= url_count_next;
    end
  end

  hrs_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (byte_valid),
    .push_stall (byte_stall),
    .push_beat  (result),
    .pop_valid  (tag_valid),
    .pop_stall  (tag_stall),
    .pop_beat   (tag_beat)
  );

  `ASSERT_NEXT(a_last_clears, accept && byte_beat.last_byte, st.phase == PH_METHOD && !st.finished && url_count == '0, "scan state not cleared after last byte")
  `ASSERT_NEXT(a_verdict_holds, accept && st.finished && !byte_beat.last_byte, st.finished && st.held_status == $past(st.held_status), "final status changed before end of stream")

endmodule
`default_nettype wire

// ===== rtl/hrs_cfg.sv =====
// APB register file holding the scanner length limits.
`timescale 1ns / 1ps
`default_nettype none
module hrs_cfg import hrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output limits_t          limits
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.method_limit  <= METHOD_LIMIT_RST;
      limits.url_limit     <= URL_LIMIT_RST;
      limits.version_limit <= VERSION_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_METHOD_LIMIT:  limits.method_limit  <= pwdata[5:0];
        REG_URL_LIMIT:     limits.url_limit     <= pwdata[11:0];
        REG_VERSION_LIMIT: limits.version_limit <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_METHOD_LIMIT:  prdata = {26'd0, limits.method_limit};
      REG_URL_LIMIT:     prdata = {20'd0, limits.url_limit};
      REG_VERSION_LIMIT: prdata = {26'd0, limits.version_limit};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/hrs_step.sv =====
// Next-state and result logic for one scanned byte.
`timescale 1ns / 1ps
`default_nettype none
module hrs_step import hrs_pkg::*; #(
  parameter int URL_COUNT_BITS = URL_COUNT_BITS_DEF
) (
  input  scan_state_t                      st,
  input  wire logic [URL_COUNT_BITS-1:0]   url_count,
  input  limits_t                          limits,
  input  in_beat_t                         beat,
  output scan_state_t                      st_next,
  output logic [URL_COUNT_BITS-1:0]        url_count_next,
  output out_beat_t                        result
);

  localparam int CmpW = (URL_COUNT_BITS > 12) ? URL_COUNT_BITS : 12;

  logic [7:0] c;
  logic       last;
  logic       url_full;
  logic [2:0] cls;
  logic       split;

  assign c    = beat.data_byte;
  assign last = beat.last_byte;

  // URL counter hits the programmed limit or saturates
  assign url_full = (CmpW'(url_count) == CmpW'(limits.url_limit)) || (&url_count);

  function automatic scan_state_t conclude(scan_state_t s, logic [3:0] code, logic crlf);
    scan_state_t r;
    r             = s;
    r.finished    = 1'b1;
    r.held_status = code;
    r.held_crlf   = crlf;
    return r;
  endfunction

  always_comb begin
    st_next        = st;
    url_count_next = url_count;
    cls            = CLS_DELIM;
    split          = 1'b0;

    if (!st.finished) begin
      // Per-phase byte handling
      unique case (st.phase)
        PH_METHOD: begin
          if (c == CH_SP) begin
            if (st.method_count == 6'd0) st_next = conclude(st_next, ST_BAD_METHOD, 1'b0);
            else st_next.phase = PH_URL;
          end else if (c == CH_CR || c == CH_LF) begin
            st_next = conclude(st_next, ST_FORMAT, 1'b0);
          end else if (st.method_count == limits.method_limit) begin
            st_next = conclude(st_next, ST_METHOD_LONG, 1'b0);
          end else begin
            st_next.method_count = st.method_count + 6'd1;
            cls = CLS_METHOD;
          end
        end
        PH_URL: begin
          if (c == CH_SP) begin
            if (url_count == '0) st_next = conclude(st_next, ST_BAD_URL, 1'b0);
            else st_next.phase = PH_VERSION;
          end else if (c == CH_CR || c == CH_LF) begin
            st_next = conclude(st_next, ST_FORMAT, 1'b0);
          end else if (url_full) begin
            st_next = conclude(st_next, ST_URL_LONG, 1'b0);
          end else begin
            url_count_next = url_count + URL_COUNT_BITS'(1);
            cls = CLS_URL;
          end
        end
        PH_VERSION: begin
          if (c == CH_CR) begin
            if (st.version_count == 6'd0 || last) st_next = conclude(st_next, ST_FORMAT, 1'b0);
            else st_next.phase = PH_VERSION_CR;
          end else if (st.version_count == limits.version_limit) begin
            st_next = conclude(st_next, ST_VERSION_LONG, 1'b0);
          end else begin
            st_next.version_count = st.version_count + 6'd1;
            cls = CLS_VERSION;
          end
        end
        PH_VERSION_CR: begin
          if (c == CH_LF) st_next.phase = PH_HDR;
          else st_next = conclude(st_next, ST_FORMAT, 1'b1);
        end
        PH_HDR, PH_HDR_BLANK: begin
          if (c == CH_CR) begin
            if (last) st_next = conclude(st_next, ST_FORMAT, 1'b0);
            else st_next.phase = (st.phase == PH_HDR) ? PH_HDR_CR : PH_HDR_BLANK_CR;
          end else if (c == CH_LF) begin
            // lone LF
            st_next = conclude(st_next, ST_HEADERS, 1'b0);
          end else begin
            st_next.phase = PH_HDR;
            cls = CLS_HEADER;
            if (c == CH_SP && st.prev_was_colon && !st.line_has_split) begin
              st_next.line_has_split = 1'b1;
              split = 1'b1;
            end
            st_next.prev_was_colon = (c == CH_COLON);
          end
        end
        PH_HDR_CR: begin
          if (c == CH_LF) begin
            if (!st.line_has_split) st_next.bad_line_seen = 1'b1;
            st_next.line_has_split = 1'b0;
            st_next.prev_was_colon = 1'b0;
            st_next.phase          = PH_HDR_BLANK;
          end else begin
            st_next = conclude(st_next, ST_FORMAT, 1'b0);
          end
        end
        PH_HDR_BLANK_CR: begin
          if (c == CH_LF) begin
            st_next = conclude(st_next, st.bad_line_seen ? ST_HEADERS : ST_OK, 1'b0);
          end else begin
            st_next = conclude(st_next, ST_FORMAT, 1'b0);
          end
        end
      endcase

      // End of stream without a verdict
      if (!st_next.finished && last) begin
        priority if (st_next.phase == PH_VERSION_CR || st_next.phase == PH_HDR_CR ||
                     st_next.phase == PH_HDR_BLANK_CR) begin
          st_next = conclude(st_next, ST_FORMAT, 1'b0);
        end else if (st_next.phase == PH_HDR || st_next.phase == PH_HDR_BLANK) begin
          st_next = conclude(st_next,
                             (st_next.bad_line_seen || !st_next.line_has_split) ?
                             ST_HEADERS : ST_OK, 1'b0);
        end else begin
          st_next = conclude(st_next, ST_HEADERS, 1'b0);
        end
      end
    end

    // Result beat
    result.echo_byte        = c;
    result.token_class      = cls;
    result.name_value_split = split;
    result.status           = st_next.finished ? st_next.held_status : ST_PENDING;
    result.crlf_error       = st_next.finished && st_next.held_crlf;

    // Last byte restarts the scanner
    if (last) begin
      st_next        = SCAN_CLEAR;
      url_count_next = '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hrs_outq.sv =====
// Two-entry result queue that decouples the scanner from output stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hrs_outq import hrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_stall,
  input  out_beat_t push_beat,
  output logic      pop_valid,
  input  wire logic pop_stall,
  output out_beat_t pop_beat
);

  out_beat_t  head;
  out_beat_t  spare;
  logic [1:0] count;
  logic [1:0] count_after_pop;
  logic       push;
  logic       pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_beat   = head;
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  assign count_after_pop = count - {1'b0, pop};

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_after_pop + {1'b0, push};
    end
  end

  // Entry data: shift forward on pop, fill first free slot on push
  always_ff @(posedge clk) begin
    if (push && count_after_pop == 2'd0) begin
      head <= push_beat;
    end else if (pop) begin
      head <= spare;
    end
    if (push && count_after_pop != 2'd0) begin
      spare <= push_beat;
    end
  end

  `ASSERT_ALWAYS(a_count_range, count != 2'd3, "result queue occupancy out of range")
  `ASSERT_NEXT(a_push_to_empty, push && !pop && count == 2'd0, pop_valid && pop_beat == $past(push_beat), "beat pushed into empty queue not at head")
  `ASSERT_NEXT(a_drain_last, pop && !push && count == 2'd1, !pop_valid, "queue still valid after last beat taken")

endmodule
`default_nettype wire

// ===== tb/http_request_header_scanner_core_tb.sv =====
// Self-checking testbench for the HTTP request header scanner core.
`timescale 1ns / 1ps
module http_request_header_scanner_core_tb;
  import hrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 40;
  localparam logic [URL_COUNT_BITS_DEF-1:0] URL_SAT = '1;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // Block ports
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  in_beat_t    byte_beat = '0;
  logic        tag_valid;
  logic        tag_stall = 1'b0;
  out_beat_t   tag_beat;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  http_request_header_scanner_core dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_beat(byte_beat),
    .tag_valid(tag_valid), .tag_stall(tag_stall), .tag_beat(tag_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Scanner shadow: limits and scan state
  logic [5:0]  lim_method;
  logic [11:0] lim_url;
  logic [5:0]  lim_version;
  phase_t      ph;
  logic [5:0]  m_cnt;
  logic [5:0]  v_cnt;
  logic [URL_COUNT_BITS_DEF-1:0] u_cnt;
  logic        colon_prev;
  logic        split_seen;
  logic        bad_line;
  logic        done;
  logic [3:0]  final_st;
  logic        final_crlf;

  // Queues, knobs and counters
  in_beat_t  byte_q[$];
  out_beat_t tag_exp_q[$];
  logic [7:0] req[$];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int beats_checked = 0;
  int bytes_sent = 0;
  int requests = 0;
  int in_stalls = 0;
  int crlf_hits = 0;
  int st_hits[16];
  logic byte_take;
  logic mism;

  function automatic void clear_scan();
    ph = PH_METHOD;
    m_cnt = '0;
    u_cnt = '0;
    v_cnt = '0;
    colon_prev = 1'b0;
    split_seen = 1'b0;
    bad_line = 1'b0;
    done = 1'b0;
    final_st = ST_PENDING;
    final_crlf = 1'b0;
  endfunction

  function automatic void finish_scan(logic [3:0] st, logic crlf);
    done = 1'b1;
    final_st = st;
    final_crlf = crlf;
    st_hits[st]++;
    if (crlf) crlf_hits++;
  endfunction

  // Tag one byte and advance the shadow scan state
  function automatic out_beat_t scan_byte(in_beat_t b);
    out_beat_t r;
    logic [7:0] c;
    c = b.data_byte;
    r.echo_byte = c;
    r.token_class = CLS_DELIM;
    r.name_value_split = 1'b0;
    if (!done) begin
      case (ph)
        PH_METHOD: begin
          if (c == CH_SP) begin
            if (m_cnt == 0) finish_scan(ST_BAD_METHOD, 1'b0);
            else ph = PH_URL;
          end else if (c == CH_CR || c == CH_LF) begin
            finish_scan(ST_FORMAT, 1'b0);
          end else if (m_cnt == lim_method) begin
            finish_scan(ST_METHOD_LONG, 1'b0);
          end else begin
            m_cnt = m_cnt + 6'd1;
            r.token_class = CLS_METHOD;
          end
        end
        PH_URL: begin
          if (c == CH_SP) begin
            if (u_cnt == 0) finish_scan(ST_BAD_URL, 1'b0);
            else ph = PH_VERSION;
          end else if (c == CH_CR || c == CH_LF) begin
            finish_scan(ST_FORMAT, 1'b0);
          end else if (u_cnt == lim_url || u_cnt == URL_SAT) begin
            finish_scan(ST_URL_LONG, 1'b0);
          end else begin
            u_cnt = u_cnt + URL_COUNT_BITS_DEF'(1);
            r.token_class = CLS_URL;
          end
        end
        PH_VERSION: begin
          if (c == CH_CR) begin
            if (v_cnt == 0 || b.last_byte) finish_scan(ST_FORMAT, 1'b0);
            else ph = PH_VERSION_CR;
          end else if (v_cnt == lim_version) begin
            finish_scan(ST_VERSION_LONG, 1'b0);
          end else begin
            v_cnt = v_cnt + 6'd1;
            r.token_class = CLS_VERSION;
          end
        end
        PH_VERSION_CR: begin
          if (c == CH_LF) ph = PH_HDR;
          else finish_scan(ST_FORMAT, 1'b1);
        end
        PH_HDR, PH_HDR_BLANK: begin
          if (c == CH_CR) begin
            if (b.last_byte) finish_scan(ST_FORMAT, 1'b0);
            else if (ph == PH_HDR) ph = PH_HDR_CR;
            else ph = PH_HDR_BLANK_CR;
          end else if (c == CH_LF) begin
            finish_scan(ST_HEADERS, 1'b0);
          end else begin
            ph = PH_HDR;
            r.token_class = CLS_HEADER;
            // first ": " of the line marks the name/value split
            if (c == CH_SP && colon_prev && !split_seen) begin
              split_seen = 1'b1;
              r.name_value_split = 1'b1;
            end
            colon_prev = (c == CH_COLON);
          end
        end
        PH_HDR_CR: begin
          if (c == CH_LF) begin
            if (!split_seen) bad_line = 1'b1;
            split_seen = 1'b0;
            colon_prev = 1'b0;
            ph = PH_HDR_BLANK;
          end else begin
            finish_scan(ST_FORMAT, 1'b0);
          end
        end
        default: begin
          if (c == CH_LF) finish_scan(bad_line ? ST_HEADERS : ST_OK, 1'b0);
          else finish_scan(ST_FORMAT, 1'b0);
        end
      endcase
      // end of stream before a final status
      if (!done && b.last_byte) begin
        if (ph == PH_VERSION_CR || ph == PH_HDR_CR || ph == PH_HDR_BLANK_CR)
          finish_scan(ST_FORMAT, 1'b0);
        else if (ph == PH_HDR || ph == PH_HDR_BLANK)
          finish_scan((bad_line || !split_seen) ? ST_HEADERS : ST_OK, 1'b0);
        else
          finish_scan(ST_HEADERS, 1'b0);
      end
    end
    r.status = done ? final_st : ST_PENDING;
    r.crlf_error = done & final_crlf;
    if (b.last_byte) clear_scan();
    return r;
  endfunction

  // Byte driver: offers queued beats, records expectations on acceptance
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_take = byte_valid && !byte_stall;
      if (byte_valid && byte_stall) in_stalls++;
      if (byte_take) begin
        tag_exp_q.insert(tag_exp_q.size(), scan_byte(byte_beat));
        bytes_sent++;
      end
      if (!byte_valid || byte_take) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          byte_beat <= byte_q.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end
  end

  // Tag monitor: compares each accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      tag_stall <= 1'b0;
    end else begin
      if (tag_valid && !tag_stall) begin
        if (tag_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected tag beat: byte=%02h cls=%0d split=%0b st=%0d crlf=%0b",
                     tag_beat.echo_byte, tag_beat.token_class,
                     tag_beat.name_value_split, tag_beat.status, tag_beat.crlf_error);
        end else begin
          mism = (tag_beat.echo_byte !== tag_exp_q[0].echo_byte) ||
                 (tag_beat.token_class !== tag_exp_q[0].token_class) ||
                 (tag_beat.name_value_split !== tag_exp_q[0].name_value_split) ||
                 (tag_beat.status !== tag_exp_q[0].status) ||
                 (tag_beat.crlf_error !== tag_exp_q[0].crlf_error);
          if (mism) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"tag beat %0d mismatch: expected byte=%02h cls=%0d split=%0b ",
                        "st=%0d crlf=%0b, got byte=%02h cls=%0d split=%0b st=%0d crlf=%0b"},
                       beats_checked, tag_exp_q[0].echo_byte, tag_exp_q[0].token_class,
                       tag_exp_q[0].name_value_split, tag_exp_q[0].status,
                       tag_exp_q[0].crlf_error, tag_beat.echo_byte, tag_beat.token_class,
                       tag_beat.name_value_split, tag_beat.status, tag_beat.crlf_error);
          end
          void'(tag_exp_q.pop_front());
          beats_checked++;
        end
      end
      tag_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               tag_exp_q.size());
      $display("http_request_header_scanner_core_tb: FAIL");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_METHOD_LIMIT:  lim_method = val[5:0];
      REG_URL_LIMIT:     lim_url = val[11:0];
      REG_VERSION_LIMIT: lim_version = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int m, input int u, input int v);
    write_reg(REG_METHOD_LIMIT, m);
    write_reg(REG_URL_LIMIT, u);
    write_reg(REG_VERSION_LIMIT, v);
  endtask

  // Wait until every byte is in and every tag beat is out
  task automatic drain();
    do @(negedge clk);
    while (byte_q.size() != 0 || byte_valid || tag_exp_q.size() != 0);
  endtask

  // Append one byte to the request being assembled
  function automatic void put_byte(logic [7:0] c);
    req.insert(req.size(), c);
  endfunction

  // Queue the assembled request, last_byte on its final byte
  function automatic void send_req();
    in_beat_t b;
    for (int i = 0; i < req.size(); i++) begin
      b.data_byte = req[i];
      b.last_byte = (i == req.size() - 1);
      byte_q.insert(byte_q.size(), b);
    end
    requests++;
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  // Character pickers for each part of a request
  function automatic logic [7:0] tok_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SP || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] ver_char();
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) return CH_LF;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] hdr_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 2) return $urandom_range(0, 1) ? CH_COLON : CH_SP;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // Token length: mostly short, sometimes exactly at the limit
  function automatic int tok_len(int lim);
    if (lim <= 64 && $urandom_range(0, 9) == 0) return lim;
    return $urandom_range(1, lim < 8 ? lim : 8);
  endfunction

  // Build one random request: well-formed, broken, over-long or noise
  function automatic void build_req();
    int kind, mlen, ulen, vlen, lf_pos, idx, nhdr, which;
    req.delete();
    kind = $urandom_range(0, 99);
    mlen = tok_len(int'(lim_method));
    ulen = tok_len(int'(lim_url));
    vlen = tok_len(int'(lim_version));
    if (kind >= 85 && kind < 93) begin
      which = $urandom_range(0, 2);
      if (which == 0) mlen = int'(lim_method) + int'($urandom_range(1, 2));
      else if (which == 1 && lim_url <= 64) ulen = int'(lim_url) + int'($urandom_range(1, 2));
      else vlen = int'(lim_version) + int'($urandom_range(1, 2));
    end
    if (kind >= 93) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat (mlen) put_byte(tok_char());
      put_byte(CH_SP);
      repeat (ulen) put_byte(tok_char());
      put_byte(CH_SP);
      repeat (vlen) put_byte(ver_char());
      add_crlf();
      lf_pos = req.size() - 1;
      nhdr = $urandom_range(0, 3);
      repeat (nhdr) begin
        repeat ($urandom_range(1, 6)) put_byte(hdr_char());
        if ($urandom_range(0, 99) < 85) begin
          put_byte(CH_COLON);
          put_byte(CH_SP);
        end
        repeat ($urandom_range(0, 6)) put_byte(hdr_char());
        add_crlf();
      end
      add_crlf();
      // a little trailing data after the blank line
      repeat ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
      if (kind >= 65 && kind < 85) begin
        idx = $urandom_range(0, req.size() - 1);
        case ($urandom_range(0, 3))
          0: begin
            // cut the stream short
            while (req.size() > idx + 1) void'(req.pop_back());
          end
          1: begin
            case ($urandom_range(0, 3))
              0: req[idx] = CH_SP;
              1: req[idx] = CH_CR;
              2: req[idx] = CH_LF;
              default: req[idx] = CH_COLON;
            endcase
          end
          2: req[idx] = 8'($urandom_range(0, 255));
          default: begin
            // version CR followed by something other than LF
            do req[lf_pos] = 8'($urandom_range(0, 255));
            while (req[lf_pos] == CH_LF);
          end
        endcase
      end
    end
  endfunction

  task automatic run_random(input int n_bytes);
    int queued;
    queued = 0;
    @(negedge clk);
    while (queued < n_bytes) begin
      build_req();
      send_req();
      queued += req.size();
    end
    drain();
  endtask

  // Stimulus sequence
  initial begin
    foreach (st_hits[i]) st_hits[i] = 0;
    lim_method = METHOD_LIMIT_RST;
    lim_url = URL_LIMIT_RST;
    lim_version = VERSION_LIMIT_RST;
    clear_scan();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: sender idles 29%, receiver 73%
    snd_idle_pct = 29;
    rcv_idle_pct = 73;
    @(negedge clk);
    // empty method
    req.delete(); put_byte(CH_SP); send_req();
    // LF in method
    req.delete(); put_byte(CH_LF); send_req();
    // end of stream in method, all bits set
    req.delete(); put_byte(8'hFF); send_req();
    // empty URL
    req.delete(); add_str("A  "); send_req();
    // CR right after the URL, with no version
    req.delete(); add_str("A B"); put_byte(CH_CR); send_req();
    // complete request with one good header line
    req.delete(); add_str("A B C"); add_crlf(); add_str("k: v"); add_crlf(); add_crlf();
    send_req();
    drain();

    // Highest limits
    set_limits(63, 4095, 63);
    run_random(600);

    // Lowest nonzero limits; sender idles 73%, receiver 29%
    snd_idle_pct = 73;
    rcv_idle_pct = 29;
    set_limits(1, 1, 1);
    run_random(500);

    // No idling; receiver holds off long enough to back up the input
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_limits($urandom_range(2, 10), $urandom_range(2, 20), $urandom_range(2, 10));
    hold_asked++;
    run_random(450);

    set_limits($urandom_range(1, 63), $urandom_range(5, 64), $urandom_range(1, 63));
    run_random(400);

    repeat (5) @(posedge clk);
    $display("ran %0d requests (%0d bytes) over five limit settings; %0d tag beats checked",
             requests, bytes_sent, beats_checked);
    $display({"final status counts: ok %0d, too long %0d/%0d/%0d, bad method %0d, ",
              "bad url %0d, format %0d (crlf %0d), headers %0d; input stall cycles %0d"},
             st_hits[ST_OK], st_hits[ST_METHOD_LONG], st_hits[ST_URL_LONG],
             st_hits[ST_VERSION_LONG], st_hits[ST_BAD_METHOD], st_hits[ST_BAD_URL],
             st_hits[ST_FORMAT], crlf_hits, st_hits[ST_HEADERS], in_stalls);
    if (mismatches == 0 && tag_exp_q.size() == 0) begin
      $display("http_request_header_scanner_core_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d beats never seen", mismatches, tag_exp_q.size());
      $display("http_request_header_scanner_core_tb: FAIL");
    end
    $finish;
  end

endmodule
